FILE: src/voxel_grid_dedup_core_defines.svh
// Assertion macros shared by the voxel grid dedup checker
`ifndef VOXEL_GRID_DEDUP_CORE_DEFINES_SVH
`define VOXEL_GRID_DEDUP_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define VGD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define VGD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

FILE: src/vgd_pkg.sv
// Types, constants and helpers of the voxel grid dedup core
`default_nettype none
package vgd_pkg;

   // controller states, one-hot
   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_ADDR  = 7'b0010000,
      ST_READ  = 7'b0100000,
      ST_CHECK = 7'b1000000
   } state_type;

   localparam int CoordW    = 32;
   localparam int SizeW     = 31;
   localparam int NumW      = 33;
   localparam int DivSteps  = 33;
   localparam int StepW     = 6;
   localparam int Lanes     = 3;
   localparam int KeyW      = 3 * CoordW;
   localparam int WordW     = KeyW + 1;

   // scale = floor((size + 50) / 4) * ScaleRecip >> ScaleShift, exact below 2^30
   localparam int ScaleShift = 35;

   localparam logic [SizeW-1:0]  SizeReset  = 31'd65536;
   localparam logic [SizeW-1:0]  ScaleBias  = 31'd50;
   localparam logic [SizeW-1:0]  ScaleRecip = 31'd1374389535;
   localparam logic [CoordW-1:0] HashPrimeX = 32'd73856093;
   localparam logic [CoordW-1:0] HashPrimeY = 32'd19349663;
   localparam logic [CoordW-1:0] HashPrimeZ = 32'd83492791;

   // clamp a signed product to the signed 32-bit range
   function automatic logic [CoordW-1:0] sat32(input logic signed [63:0] p);
      logic [CoordW-1:0] r;
      if (p > 64'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (p < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = p[CoordW-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: src/voxel_grid_dedup_core.sv
// Voxel grid filter: quantize points, dedupe voxel indexes in a hash set
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+------------------------------
//  request  | req_point_valid, req_coord_*   | start while busy low
//  response | rsp_index_*, rsp_center_*, ... | rsp_strobe, one cycle
//  csr      | csr_voxel_size                 | csr_valid and csr_ready
//
// An invalid point is dropped without a result. A valid point is quantized
// by a 33-step restoring divider (one bit per cycle, three lanes), then
// probes slots, each probe a read then a compare on the slot memory. After
// reset a clearing pass over every slot keeps busy high. The receiver
// cannot stall; a result shows for one cycle.
`default_nettype none
module voxel_grid_dedup_core #(
   parameter int SET_CAPACITY = 4096  // power of two
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_point_valid,
   input  wire logic [31:0] req_coord_x,
   input  wire logic [31:0] req_coord_y,
   input  wire logic [31:0] req_coord_z,
   output logic             rsp_strobe,
   output logic [31:0]      rsp_index_x,
   output logic [31:0]      rsp_index_y,
   output logic [31:0]      rsp_index_z,
   output logic [31:0]      rsp_center_x,
   output logic [31:0]      rsp_center_y,
   output logic [31:0]      rsp_center_z,
   output logic [30:0]      rsp_cube_scale,
   output logic             rsp_table_full,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [30:0] csr_voxel_size
);

   localparam int AddrW = $clog2(SET_CAPACITY);
   localparam logic [AddrW:0] LastProbe = (AddrW + 1)'(SET_CAPACITY - 1);

   vgd_pkg::state_type state_ff, state_in;
   logic [vgd_pkg::SizeW-1:0]  size_ff, eff_size;
   logic [vgd_pkg::SizeW-1:0]  eff_ff;
   logic [vgd_pkg::StepW-1:0]  step_ff, step_in;
   logic [AddrW-1:0]           clr_ff, clr_in;
   logic                       strobe_ff, strobe_in;
   logic                       accept;

   logic [2:0]                 neg_ff;
   logic [vgd_pkg::CoordW-1:0] rem_ff [vgd_pkg::Lanes];
   logic [vgd_pkg::CoordW-1:0] rem_in [vgd_pkg::Lanes];
   logic [vgd_pkg::NumW-1:0]   quo_ff [vgd_pkg::Lanes];
   logic [vgd_pkg::NumW-1:0]   quo_in [vgd_pkg::Lanes];
   logic [vgd_pkg::CoordW-1:0] den_ff [vgd_pkg::Lanes];
   logic [vgd_pkg::NumW-1:0]   trial  [vgd_pkg::Lanes];
   logic [vgd_pkg::CoordW-1:0] mag    [3];
   logic [vgd_pkg::CoordW-1:0] coord  [3];
   logic [vgd_pkg::CoordW-1:0] idx_c  [3];
   logic [vgd_pkg::CoordW-1:0] idx_ff [3];
   logic signed [63:0]         prod_ff [3];
   logic [vgd_pkg::CoordW-1:0] hsh_ff [3];
   logic [vgd_pkg::CoordW-1:0] hsh_prime [3];
   logic [vgd_pkg::CoordW-1:0] center_ff [3];
   logic [vgd_pkg::SizeW-1:0]  scale_ff;
   logic [vgd_pkg::CoordW-1:0] scale_num;
   logic [63:0]                scale_prod;
   logic                       full_ff;

   logic [AddrW-1:0]           slot_ff;
   logic [AddrW:0]             probe_ff;
   logic [vgd_pkg::WordW-1:0]  mem [SET_CAPACITY];
   logic [vgd_pkg::WordW-1:0]  rd_ff;
   logic                       mem_we;
   logic [AddrW-1:0]           mem_wa;
   logic [vgd_pkg::WordW-1:0]  mem_wd;
   logic                       slot_used, key_hit;

   assign busy      = (state_ff != vgd_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign eff_size  = (size_ff == '0) ? vgd_pkg::SizeW'(1) : size_ff;
   assign coord[0]  = req_coord_x;
   assign coord[1]  = req_coord_y;
   assign coord[2]  = req_coord_z;
   assign hsh_prime[0] = vgd_pkg::HashPrimeX;
   assign hsh_prime[1] = vgd_pkg::HashPrimeY;
   assign hsh_prime[2] = vgd_pkg::HashPrimeZ;

   // render scale: divide size + 50 by 100 with a reciprocal multiply
   assign scale_num  = {1'b0, eff_ff} + {1'b0, vgd_pkg::ScaleBias};
   assign scale_prod = 64'(scale_num[vgd_pkg::CoordW-1:2]) * 64'(vgd_pkg::ScaleRecip);

   // magnitude of each coordinate and signed index from the quotient
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i]   = coord[i][31] ? (~coord[i] + 32'd1) : coord[i];
         idx_c[i] = neg_ff[i] ? (~quo_ff[i][31:0] + 32'd1) : quo_ff[i][31:0];
      end
   end

   // one restoring divide step per lane
   always_comb begin
      for (int i = 0; i < vgd_pkg::Lanes; i++) begin
         trial[i] = {rem_ff[i], quo_ff[i][vgd_pkg::NumW-1]};
         if (trial[i] >= {1'b0, den_ff[i]}) begin
            rem_in[i] = vgd_pkg::CoordW'(trial[i] - {1'b0, den_ff[i]});
            quo_in[i] = {quo_ff[i][vgd_pkg::NumW-2:0], 1'b1};
         end else begin
            rem_in[i] = trial[i][vgd_pkg::CoordW-1:0];
            quo_in[i] = {quo_ff[i][vgd_pkg::NumW-2:0], 1'b0};
         end
      end
   end

   // decode the slot word read last cycle
   assign slot_used = rd_ff[vgd_pkg::KeyW];
   assign key_hit   = (rd_ff[vgd_pkg::KeyW-1:0] == {idx_ff[0], idx_ff[1], idx_ff[2]});

   // sequence clear, divide, multiply, probe
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      clr_in    = clr_ff;
      strobe_in = 1'b0;
      mem_we    = 1'b0;
      mem_wa    = slot_ff;
      mem_wd    = {1'b1, idx_ff[0], idx_ff[1], idx_ff[2]};
      case (state_ff)
         vgd_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + AddrW'(1);
            if (clr_ff == '1) begin
               state_in = vgd_pkg::ST_IDLE;
            end
         end
         vgd_pkg::ST_IDLE: begin
            step_in = '0;
            if (accept && req_point_valid) begin
               state_in = vgd_pkg::ST_DIV;
            end
         end
         vgd_pkg::ST_DIV: begin
            step_in = step_ff + vgd_pkg::StepW'(1);
            if (step_ff == vgd_pkg::StepW'(vgd_pkg::DivSteps - 1)) begin
               state_in = vgd_pkg::ST_MUL;
            end
         end
         vgd_pkg::ST_MUL: begin
            state_in = vgd_pkg::ST_ADDR;
         end
         vgd_pkg::ST_ADDR: begin
            state_in = vgd_pkg::ST_READ;
         end
         vgd_pkg::ST_READ: begin
            state_in = vgd_pkg::ST_CHECK;
         end
         vgd_pkg::ST_CHECK: begin
            if (!slot_used) begin
               mem_we    = 1'b1;
               strobe_in = 1'b1;
               state_in  = vgd_pkg::ST_IDLE;
            end else if (key_hit) begin
               state_in = vgd_pkg::ST_IDLE;
            end else if (probe_ff == LastProbe) begin
               strobe_in = 1'b1;
               state_in  = vgd_pkg::ST_IDLE;
            end else begin
               state_in = vgd_pkg::ST_READ;
            end
         end
         default: begin
            state_in = vgd_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= vgd_pkg::ST_CLEAR;
         step_ff   <= '0;
         clr_ff    <= '0;
         strobe_ff <= 1'b0;
         size_ff   <= vgd_pkg::SizeReset;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         clr_ff    <= clr_in;
         strobe_ff <= strobe_in;
         if (csr_valid && csr_ready) begin
            size_ff <= csr_voxel_size;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         vgd_pkg::ST_IDLE: begin
            if (accept) begin
               eff_ff <= eff_size;
               for (int i = 0; i < 3; i++) begin
                  neg_ff[i] <= coord[i][31];
                  rem_ff[i] <= '0;
                  quo_ff[i] <= {mag[i], 1'b0} + vgd_pkg::NumW'(eff_size);
                  den_ff[i] <= {eff_size, 1'b0};
               end
            end
         end
         vgd_pkg::ST_DIV: begin
            for (int i = 0; i < vgd_pkg::Lanes; i++) begin
               rem_ff[i] <= rem_in[i];
               quo_ff[i] <= quo_in[i];
            end
         end
         vgd_pkg::ST_MUL: begin
            for (int i = 0; i < 3; i++) begin
               idx_ff[i]  <= idx_c[i];
               prod_ff[i] <= $signed(idx_c[i]) * $signed({1'b0, eff_ff});
               hsh_ff[i]  <= idx_c[i] * hsh_prime[i];
            end
            scale_ff <= vgd_pkg::SizeW'(scale_prod >> vgd_pkg::ScaleShift);
         end
         vgd_pkg::ST_ADDR: begin
            for (int i = 0; i < 3; i++) begin
               center_ff[i] <= vgd_pkg::sat32(prod_ff[i]);
            end
            slot_ff  <= AddrW'(hsh_ff[0] ^ hsh_ff[1] ^ hsh_ff[2]);
            probe_ff <= '0;
            full_ff  <= 1'b0;
         end
         vgd_pkg::ST_CHECK: begin
            // advance to the next slot on an occupied mismatch
            if (slot_used && !key_hit) begin
               slot_ff  <= slot_ff + AddrW'(1);
               probe_ff <= probe_ff + (AddrW + 1)'(1);
               full_ff  <= (probe_ff == LastProbe);
            end
         end
         default: begin
         end
      endcase
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (state_ff == vgd_pkg::ST_READ) begin
         rd_ff <= mem[slot_ff];
      end
   end

   // drive the response word
   assign rsp_strobe     = strobe_ff;
   assign rsp_index_x    = idx_ff[0];
   assign rsp_index_y    = idx_ff[1];
   assign rsp_index_z    = idx_ff[2];
   assign rsp_center_x   = center_ff[0];
   assign rsp_center_y   = center_ff[1];
   assign rsp_center_z   = center_ff[2];
   assign rsp_cube_scale = scale_ff;
   assign rsp_table_full = full_ff;

endmodule
`default_nettype wire

FILE: src/vgd_checker.sv
// Port-level checker for the voxel grid dedup core, with its bind
`default_nettype none
`include "voxel_grid_dedup_core_defines.svh"
module vgd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_point_valid,
   input wire logic rsp_strobe
);

   // a result closes a busy stretch
   `VGD_ASSERT_NOW(a_rsp_after_busy, clock, reset, rsp_strobe, $past(busy))
   `VGD_ASSERT_NOW(a_rsp_when_idle, clock, reset, rsp_strobe, !busy)
   // at most one result per word
   `VGD_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_strobe, !rsp_strobe)
   // a skipped point does not occupy the core
   `VGD_ASSERT_NEXT(a_skip_fast, clock, reset, start && !busy && !req_point_valid,
                    !busy && !rsp_strobe)

endmodule

bind voxel_grid_dedup_core vgd_checker u_vgd_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_point_valid (req_point_valid),
   .rsp_strobe      (rsp_strobe)
);
`default_nettype wire
